>>> hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// shared types, constants and helpers for the channel-shifted convolution
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int unsigned DEF_MAX_BATCH        = 2;
    localparam int unsigned DEF_MAX_ROWS         = 32;
    localparam int unsigned DEF_MAX_COLS         = 32;
    localparam int unsigned DEF_MAX_CHANNELS     = 16;
    localparam int unsigned DEF_MAX_OUT_CHANNELS = 16;
    localparam int unsigned DEF_MAX_KERNEL       = 7;

    localparam int unsigned IN_BITS  = 48;
    localparam int unsigned OUT_BITS = 48;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    typedef enum logic [1:0] {
        OP_IMAGE  = 2'd0,
        OP_FILTER = 2'd1,
        OP_BASE   = 2'd2,
        OP_CONV   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_BATCH   = 3'd0,
        REG_ROWS    = 3'd1,
        REG_COLS    = 3'd2,
        REG_CHANS   = 3'd3,
        REG_OCHANS  = 3'd4,
        REG_KROWS   = 3'd5,
        REG_KCOLS   = 3'd6,
        REG_FILL    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        batch_idx;
        logic [4:0]  row_idx;
        logic [4:0]  col_idx;
        logic [3:0]  chan_idx;
        logic [3:0]  out_chan_idx;
        logic [2:0]  tap_row;
        logic [2:0]  tap_col;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]  batch_count;
        logic [5:0]  image_rows;
        logic [5:0]  image_cols;
        logic [4:0]  channel_count;
        logic [4:0]  out_channel_count;
        logic [2:0]  kernel_rows;
        logic [2:0]  kernel_cols;
        logic [15:0] fill_value;
    } cfg_t;

    // clamp a size register to [1, hi]
    function automatic logic [10:0] clamp_size(input logic [5:0] v, input logic [10:0] hi);
        logic [10:0] w;
        begin
            w = {5'd0, v};
            if (w == 11'd0)
                clamp_size = 11'd1;
            else if (w > hi)
                clamp_size = hi;
            else
                clamp_size = w;
        end
    endfunction

endpackage

>>> hw/rtl/channel_shifted_conv2d_forward.sv
// ----------------------------------------------------------------------------
// channel_shifted_conv2d_forward
// channel-shifted same-padded convolution with on-chip stores
//
// channel   dir  fields
// s_axis    in   tdata: batch, row, col, chan, out_chan, tap_row, tap_col, value
//                tuser: operation
// m_axis    out  tdata: conv_sum
// cfg       in   write enable, index, data
//
// a store write is done by the back end straight from the queue head; a compute
// walks each tap and channel through the shared multiply-accumulate loop, or gives zero if out of range
// stores have no reset; config is captured at once
// input queue lets loads arrive while a result waits on m_tready
// ----------------------------------------------------------------------------
module channel_shifted_conv2d_forward
    import csc_pkg::*;
#(
    parameter int unsigned MAX_BATCH        = DEF_MAX_BATCH,
    parameter int unsigned MAX_ROWS         = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS         = DEF_MAX_COLS,
    parameter int unsigned MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int unsigned MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
    parameter int unsigned MAX_KERNEL       = DEF_MAX_KERNEL
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // batch_idx, row_idx, col_idx, chan_idx, out_chan_idx, tap_row, tap_col, value
    input  logic [IN_BITS-1:0]       s_tdata,
    // operation
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // conv_sum
    output logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batch_count       <= 2'd1;
            cfg_reg.image_rows        <= 6'd32;
            cfg_reg.image_cols        <= 6'd32;
            cfg_reg.channel_count     <= 5'd16;
            cfg_reg.out_channel_count <= 5'd16;
            cfg_reg.kernel_rows       <= 3'd3;
            cfg_reg.kernel_cols       <= 3'd3;
            cfg_reg.fill_value        <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BATCH:  cfg_reg.batch_count       <= cfg_data[1:0];
                REG_ROWS:   cfg_reg.image_rows        <= cfg_data[5:0];
                REG_COLS:   cfg_reg.image_cols        <= cfg_data[5:0];
                REG_CHANS:  cfg_reg.channel_count     <= cfg_data[4:0];
                REG_OCHANS: cfg_reg.out_channel_count <= cfg_data[4:0];
                REG_KROWS:  cfg_reg.kernel_rows       <= cfg_data[2:0];
                REG_KCOLS:  cfg_reg.kernel_cols       <= cfg_data[2:0];
                REG_FILL:   cfg_reg.fill_value        <= cfg_data;
                default:    ;
            endcase
        end
    end

    csc_front #(.DEPTH(2)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    csc_back #(
        .MAX_BATCH        (MAX_BATCH),
        .MAX_ROWS         (MAX_ROWS),
        .MAX_COLS         (MAX_COLS),
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_KERNEL       (MAX_KERNEL)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hw/rtl/csc_front.sv
// ----------------------------------------------------------------------------
// csc_front
// input queue: unpacks beats into items and pushes them into a small queue
// ----------------------------------------------------------------------------
module csc_front
    import csc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                q_valid,
    input  logic                q_pop,
    output item_t               q_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    item_t           in_item;
    logic            push;
    logic            pop;

    always_comb
    begin
        in_item.operation    = s_tuser;
        in_item.batch_idx    = s_tdata[0];
        in_item.row_idx      = s_tdata[5:1];
        in_item.col_idx      = s_tdata[10:6];
        in_item.chan_idx     = s_tdata[14:11];
        in_item.out_chan_idx = s_tdata[18:15];
        in_item.tap_row      = s_tdata[21:19];
        in_item.tap_col      = s_tdata[24:22];
        in_item.value        = s_tdata[40:25];
    end

    assign s_tready = (cnt_reg != (PW+1)'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(DEPTH)) else $error("queue overfill");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("push lost");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 1'b1) else $error("pop lost");

endmodule

>>> hw/rtl/csc_back.sv
// ----------------------------------------------------------------------------
// csc_back
// executes store writes and walks taps and channels for a convolution
// ----------------------------------------------------------------------------
module csc_back
    import csc_pkg::*;
#(
    parameter int unsigned MAX_BATCH        = DEF_MAX_BATCH,
    parameter int unsigned MAX_ROWS         = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS         = DEF_MAX_COLS,
    parameter int unsigned MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int unsigned MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
    parameter int unsigned MAX_KERNEL       = DEF_MAX_KERNEL
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_valid,
    output logic                q_pop,
    input  item_t               q_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam int unsigned IMG_DEPTH  = MAX_BATCH * MAX_ROWS * MAX_COLS * MAX_CHANNELS;
    localparam int unsigned FLT_DEPTH  = MAX_OUT_CHANNELS * MAX_KERNEL * MAX_KERNEL
                                         * MAX_CHANNELS;
    localparam int unsigned BASE_DEPTH = MAX_BATCH * MAX_ROWS * MAX_COLS;
    localparam int unsigned IA = $clog2(IMG_DEPTH) > 0 ? $clog2(IMG_DEPTH) : 1;
    localparam int unsigned FA = $clog2(FLT_DEPTH) > 0 ? $clog2(FLT_DEPTH) : 1;
    localparam int unsigned BA = $clog2(BASE_DEPTH) > 0 ? $clog2(BASE_DEPTH) : 1;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CENTRE = 9'b000000010,
        ST_CWAIT  = 9'b000000100,
        ST_TAP    = 9'b000001000,
        ST_TWAIT  = 9'b000010000,
        ST_CHAN   = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_ACC    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    logic [15:0] img_mem  [IMG_DEPTH];
    logic [15:0] flt_mem  [FLT_DEPTH];
    logic [15:0] base_mem [BASE_DEPTH];

    state_t state_reg, state_next;
    item_t  cur_reg;
    logic [3:0]  tr_reg, tc_reg;
    logic [8:0]  ch_reg;
    logic signed [15:0] centre_reg;
    logic signed [16:0] delta_reg;
    logic        inside_reg;
    logic signed [15:0] img0_reg, img1_reg, flt_reg, base_rd_reg;
    logic signed [24:0] frac_reg;
    logic        use_fill_reg;
    logic signed [33:0] samp_reg;
    logic signed [63:0] acc_reg;
    logic [OUT_BITS-1:0] out_reg;
    logic        out_valid_reg;

    logic [10:0] rows, cols, chs, kr, kc, bs, ocs;
    logic signed [12:0] ir, ic;
    logic        tap_inside;
    logic signed [25:0] p;
    logic        p_ok;
    logic [IA-1:0] img_a0, img_a1;
    logic [FA-1:0] flt_a;
    logic [BA-1:0] base_a;
    logic        wr_ok, in_range;

    always_comb
    begin
        rows = clamp_size(cfg.image_rows, 11'(MAX_ROWS));
        cols = clamp_size(cfg.image_cols, 11'(MAX_COLS));
        chs  = clamp_size({1'b0, cfg.channel_count}, 11'(MAX_CHANNELS));
        kr   = clamp_size({3'd0, cfg.kernel_rows}, 11'(MAX_KERNEL));
        kc   = clamp_size({3'd0, cfg.kernel_cols}, 11'(MAX_KERNEL));
        bs   = clamp_size({4'd0, cfg.batch_count}, 11'(MAX_BATCH));
        ocs  = clamp_size({1'b0, cfg.out_channel_count}, 11'(MAX_OUT_CHANNELS));
        ir = $signed({8'd0, cur_reg.row_idx}) - $signed({2'd0, kr >> 1}) + $signed({9'd0, tr_reg});
        ic = $signed({8'd0, cur_reg.col_idx}) - $signed({2'd0, kc >> 1}) + $signed({9'd0, tc_reg});
        tap_inside = (ir >= 0) && (ir < $signed({2'd0, rows}))
                  && (ic >= 0) && (ic < $signed({2'd0, cols}));
        p = $signed({{9{delta_reg[16]}}, delta_reg}) + $signed({9'd0, ch_reg, 8'd0});
        p_ok = inside_reg && (p >= 0) && (p < $signed({7'd0, chs - 11'd1, 8'd0}));
        in_range = (11'(cur_reg.batch_idx) < bs) && (11'(cur_reg.row_idx) < rows)
                && (11'(cur_reg.col_idx) < cols) && (11'(cur_reg.out_chan_idx) < ocs);
    end

    // addresses
    always_comb
    begin
        img_a0 = IA'((((32'(cur_reg.batch_idx) * MAX_ROWS + 32'(ir[9:0])) * MAX_COLS
                 + 32'(ic[9:0])) * MAX_CHANNELS) + 32'(p[15:8]));
        img_a1 = img_a0 + 1'b1;
        flt_a  = FA'((((32'(cur_reg.out_chan_idx) * MAX_KERNEL + 32'(tr_reg)) * MAX_KERNEL
                 + 32'(tc_reg)) * MAX_CHANNELS) + 32'(ch_reg));
        base_a = BA'((32'(cur_reg.batch_idx) * MAX_ROWS + 32'(ir[9:0])) * MAX_COLS
                 + 32'(ic[9:0]));
        if (state_reg == ST_CENTRE)
            base_a = BA'((32'(cur_reg.batch_idx) * MAX_ROWS + 32'(cur_reg.row_idx))
                     * MAX_COLS + 32'(cur_reg.col_idx));
    end

    // store writes straight from the queue head
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            case (q_item.operation)
                OP_IMAGE:
                    if (32'(q_item.batch_idx) < MAX_BATCH && 32'(q_item.row_idx) < MAX_ROWS
                        && 32'(q_item.col_idx) < MAX_COLS && 32'(q_item.chan_idx) < MAX_CHANNELS)
                        img_mem[IA'((((32'(q_item.batch_idx) * MAX_ROWS + 32'(q_item.row_idx))
                            * MAX_COLS + 32'(q_item.col_idx)) * MAX_CHANNELS)
                            + 32'(q_item.chan_idx))] <= q_item.value;
                OP_FILTER:
                    if (32'(q_item.out_chan_idx) < MAX_OUT_CHANNELS
                        && 32'(q_item.tap_row) < MAX_KERNEL && 32'(q_item.tap_col) < MAX_KERNEL
                        && 32'(q_item.chan_idx) < MAX_CHANNELS)
                        flt_mem[FA'((((32'(q_item.out_chan_idx) * MAX_KERNEL
                            + 32'(q_item.tap_row)) * MAX_KERNEL + 32'(q_item.tap_col))
                            * MAX_CHANNELS) + 32'(q_item.chan_idx))] <= q_item.value;
                OP_BASE:
                    if (32'(q_item.batch_idx) < MAX_BATCH && 32'(q_item.row_idx) < MAX_ROWS
                        && 32'(q_item.col_idx) < MAX_COLS)
                        base_mem[BA'((32'(q_item.batch_idx) * MAX_ROWS + 32'(q_item.row_idx))
                            * MAX_COLS + 32'(q_item.col_idx))] <= q_item.value;
                default:
                    ;
            endcase
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        base_rd_reg <= base_mem[base_a];
        img0_reg    <= img_mem[img_a0];
        img1_reg    <= img_mem[img_a1];
        flt_reg     <= flt_mem[flt_a];
    end

    assign wr_ok = 1'b1;
    assign q_pop = (state_reg == ST_IDLE) && q_valid
                && ((q_item.operation != OP_CONV) || !out_valid_reg) && wr_ok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_pop && q_item.operation == OP_CONV) state_next = ST_CENTRE;
            ST_CENTRE: state_next = in_range ? ST_CWAIT : ST_OUT;
            ST_CWAIT:  state_next = ST_TAP;
            ST_TAP:    state_next = ST_TWAIT;
            ST_TWAIT:  state_next = ST_CHAN;
            ST_CHAN:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:
            begin
                if (11'(ch_reg) + 11'd1 < chs)
                    state_next = ST_CHAN;
                else if (11'(tc_reg) + 11'd1 < kc)
                    state_next = ST_TAP;
                else if (11'(tr_reg) + 11'd1 < kr)
                    state_next = ST_TAP;
                else
                    state_next = ST_OUT;
            end
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= q_item;
                tr_reg  <= '0;
                tc_reg  <= '0;
                ch_reg  <= '0;
                acc_reg <= '0;
            end
            ST_CWAIT:
                centre_reg <= base_rd_reg;
            ST_TAP:
                inside_reg <= tap_inside;
            ST_TWAIT:
                delta_reg <= inside_reg ? (17'(base_rd_reg) - 17'(centre_reg)) : '0;
            ST_CHAN:
            begin
                use_fill_reg <= !p_ok;
                frac_reg     <= 25'(p[7:0]);
            end
            ST_MUL:
                samp_reg <= use_fill_reg ? (34'(img0_reg) <<< 8)
                          : (34'(img0_reg) * 34'(25'd256 - frac_reg) + 34'(img1_reg) * 34'(frac_reg));
            ST_ACC:
            begin
                acc_reg <= acc_reg + (64'(use_fill_reg ? (34'($signed(cfg.fill_value)) <<< 8)
                                           : samp_reg) * 64'(flt_reg));
                if (11'(ch_reg) + 11'd1 < chs)
                    ch_reg <= ch_reg + 1'b1;
                else
                begin
                    ch_reg <= '0;
                    if (11'(tc_reg) + 11'd1 < kc)
                        tc_reg <= tc_reg + 1'b1;
                    else
                    begin
                        tc_reg <= '0;
                        tr_reg <= tr_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
                out_reg <= in_range ? OUT_BITS'((acc_reg + 64'sd128) >>> 8) : '0;
            default:
                ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.operation == OP_CONV) |-> !out_valid_reg) else $error("result overrun");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && state_reg != ST_OUT) |=> $stable(m_tdata))
        else $error("result changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop) else $error("pop while busy");

endmodule

>>> verif/channel_shifted_conv2d_forward_tb.sv
// ----------------------------------------------------------------------------
// channel_shifted_conv2d_forward_tb
// self-checking bench for the channel-shifted convolution: store loads and
// compute beats go in over the slave stream, every sum is predicted in the
// bench and compared with the master stream, across several register
// settings and with random idling on both sides
// ----------------------------------------------------------------------------
module channel_shifted_conv2d_forward_tb
    import csc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_DEPTH  = 2 * 32 * 32 * 16;
    localparam int FLT_DEPTH  = 16 * 7 * 7 * 16;
    localparam int BASE_DEPTH = 2 * 32 * 32;
    localparam int SETTLE     = 2600;
    localparam longint LIMIT  = 3000000;

    class conv_scoreboard;
        logic [15:0] image_mem[IMG_DEPTH];
        logic [15:0] filter_mem[FLT_DEPTH];
        logic [15:0] base_mem[BASE_DEPTH];
        logic [1:0]  batch_count;
        logic [5:0]  image_rows;
        logic [5:0]  image_cols;
        logic [4:0]  channel_count;
        logic [4:0]  out_channel_count;
        logic [2:0]  kernel_rows;
        logic [2:0]  kernel_cols;
        logic [15:0] fill_value;
        logic [47:0] sums_due[$];
        int          errors;
        int          sums_seen;
        int          loads_seen;

        function new();
            batch_count = 1;
            image_rows = 32;
            image_cols = 32;
            channel_count = 16;
            out_channel_count = 16;
            kernel_rows = 3;
            kernel_cols = 3;
            fill_value = 0;
            errors = 0;
            sums_seen = 0;
            loads_seen = 0;
        endfunction

        function int clamp(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int n_batch();  return clamp(int'(batch_count), 2);        endfunction
        function int n_rows();   return clamp(int'(image_rows), 32);        endfunction
        function int n_cols();   return clamp(int'(image_cols), 32);        endfunction
        function int n_chans();  return clamp(int'(channel_count), 16);     endfunction
        function int n_ochans(); return clamp(int'(out_channel_count), 16); endfunction
        function int n_krows();  return clamp(int'(kernel_rows), 7);        endfunction
        function int n_kcols();  return clamp(int'(kernel_cols), 7);        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] d);
            case (idx)
                REG_BATCH:  batch_count = d[1:0];
                REG_ROWS:   image_rows = d[5:0];
                REG_COLS:   image_cols = d[5:0];
                REG_CHANS:  channel_count = d[4:0];
                REG_OCHANS: out_channel_count = d[4:0];
                REG_KROWS:  kernel_rows = d[2:0];
                REG_KCOLS:  kernel_cols = d[2:0];
                REG_FILL:   fill_value = d;
                default: ;
            endcase
        endfunction

        function logic [47:0] conv_sum(int b, int h, int w, int oc);
            longint acc;
            longint centre;
            longint delta;
            longint p;
            longint s;
            longint fv;
            longint fill;
            int kr;
            int kc;
            int chs;
            int ir;
            int ic;
            int n;
            int fr;
            int bidx;
            bit in_img;
            acc = 0;
            kr = n_krows();
            kc = n_kcols();
            chs = n_chans();
            fill = longint'($signed(fill_value));
            centre = longint'($signed(base_mem[(b * 32 + h) * 32 + w]));
            for (int tr = 0; tr < kr; tr++)
                for (int tc = 0; tc < kc; tc++)
                begin
                    ir = h - kr / 2 + tr;
                    ic = w - kc / 2 + tc;
                    in_img = ir >= 0 && ir < n_rows() && ic >= 0 && ic < n_cols();
                    delta = in_img
                        ? longint'($signed(base_mem[(b * 32 + ir) * 32 + ic])) - centre : 0;
                    for (int c = 0; c < chs; c++)
                    begin
                        fv = longint'($signed(filter_mem[((oc * 7 + tr) * 7 + tc) * 16 + c]));
                        p = delta + c * 256;
                        if (in_img && p >= 0 && p < (chs - 1) * 256)
                        begin
                            n = int'(p >>> 8);
                            fr = int'(p & 255);
                            bidx = ((b * 32 + ir) * 32 + ic) * 16;
                            s = longint'($signed(image_mem[bidx + n])) * (256 - fr)
                              + longint'($signed(image_mem[bidx + n + 1])) * fr;
                            acc += s * fv;
                        end
                        else
                            acc += fill * fv * 256;
                    end
                end
            acc = (acc + 128) >>> 8;
            return acc[47:0];
        endfunction

        function void note_beat(item_t it);
            int b;
            int r;
            int c;
            int ch;
            int oc;
            int tr;
            int tc;
            b = int'(it.batch_idx);
            r = int'(it.row_idx);
            c = int'(it.col_idx);
            ch = int'(it.chan_idx);
            oc = int'(it.out_chan_idx);
            tr = int'(it.tap_row);
            tc = int'(it.tap_col);
            case (op_t'(it.operation))
                OP_IMAGE:
                begin
                    image_mem[((b * 32 + r) * 32 + c) * 16 + ch] = it.value;
                    loads_seen++;
                end
                OP_FILTER:
                begin
                    if (tr < 7 && tc < 7)
                        filter_mem[((oc * 7 + tr) * 7 + tc) * 16 + ch] = it.value;
                    loads_seen++;
                end
                OP_BASE:
                begin
                    base_mem[(b * 32 + r) * 32 + c] = it.value;
                    loads_seen++;
                end
                default:
                begin
                    if (b < n_batch() && r < n_rows() && c < n_cols() && oc < n_ochans())
                        sums_due.push_back(conv_sum(b, r, c, oc));
                    else
                        sums_due.push_back(48'd0);
                end
            endcase
        endfunction

        function void check_beat(logic [47:0] got);
            logic [47:0] want;
            sums_seen++;
            if (sums_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected sum beat, expected none, actual %h", $time, got);
                return;
            end
            want = sums_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: conv_sum mismatch, expected %h, actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata;
    logic [1:0]               s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_BITS-1:0]      m_tdata;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    conv_scoreboard sb;
    bit     image_wr[IMG_DEPTH];
    bit     filter_wr[FLT_DEPTH];
    bit     base_wr[BASE_DEPTH];
    int     send_idle;
    int     recv_idle;
    int     hold_left;
    int     computes_sent;
    longint cycles;

    channel_shifted_conv2d_forward u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("channel_shifted_conv2d_forward_tb: FAIL");
            $finish;
        end
    end

    // result side: check the beat, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_beat(item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.operation;
        s_tdata <= {7'd0, it.value, it.tap_col, it.tap_row, it.out_chan_idx, it.chan_idx,
                    it.col_idx, it.row_idx, it.batch_idx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(it);
    endtask

    task automatic put_load(op_t op, int b, int r, int c, int ch, int oc, int tr, int tc,
                            logic [15:0] v);
        item_t it;
        it = '0;
        it.operation = op;
        it.batch_idx = 1'(b);
        it.row_idx = 5'(r);
        it.col_idx = 5'(c);
        it.chan_idx = 4'(ch);
        it.out_chan_idx = 4'(oc);
        it.tap_row = 3'(tr);
        it.tap_col = 3'(tc);
        it.value = v;
        send_beat(it);
        case (op)
            OP_IMAGE:  image_wr[((b * 32 + r) * 32 + c) * 16 + ch] = 1'b1;
            OP_BASE:   base_wr[(b * 32 + r) * 32 + c] = 1'b1;
            OP_FILTER: if (tr < 7 && tc < 7) filter_wr[((oc * 7 + tr) * 7 + tc) * 16 + ch] = 1'b1;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_base();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 1279)) - 16'd640;
    endfunction

    // load every store entry that this compute would read and that is still empty
    task automatic fill_gaps(int b, int h, int w, int oc);
        int kr;
        int kc;
        int chs;
        int ir;
        int ic;
        int n;
        int bidx;
        longint delta;
        longint p;
        kr = sb.n_krows();
        kc = sb.n_kcols();
        chs = sb.n_chans();
        if (!base_wr[(b * 32 + h) * 32 + w])
            put_load(OP_BASE, b, h, w, 0, 0, 0, 0, rand_base());
        for (int tr = 0; tr < kr; tr++)
            for (int tc = 0; tc < kc; tc++)
            begin
                ir = h - kr / 2 + tr;
                ic = w - kc / 2 + tc;
                if (ir >= 0 && ir < sb.n_rows() && ic >= 0 && ic < sb.n_cols()
                    && !base_wr[(b * 32 + ir) * 32 + ic])
                    put_load(OP_BASE, b, ir, ic, 0, 0, 0, 0, rand_base());
                for (int c = 0; c < chs; c++)
                    if (!filter_wr[((oc * 7 + tr) * 7 + tc) * 16 + c])
                        put_load(OP_FILTER, 0, 0, 0, c, oc, tr, tc, rand_sample());
            end
        for (int tr = 0; tr < kr; tr++)
            for (int tc = 0; tc < kc; tc++)
            begin
                ir = h - kr / 2 + tr;
                ic = w - kc / 2 + tc;
                if (ir >= 0 && ir < sb.n_rows() && ic >= 0 && ic < sb.n_cols())
                begin
                    delta = longint'($signed(sb.base_mem[(b * 32 + ir) * 32 + ic]))
                          - longint'($signed(sb.base_mem[(b * 32 + h) * 32 + w]));
                    bidx = ((b * 32 + ir) * 32 + ic) * 16;
                    for (int c = 0; c < chs; c++)
                    begin
                        p = delta + c * 256;
                        if (p >= 0 && p < (chs - 1) * 256)
                        begin
                            n = int'(p >>> 8);
                            if (!image_wr[bidx + n])
                                put_load(OP_IMAGE, b, ir, ic, n, 0, 0, 0, rand_sample());
                            if (!image_wr[bidx + n + 1])
                                put_load(OP_IMAGE, b, ir, ic, n + 1, 0, 0, 0, rand_sample());
                        end
                    end
                end
            end
    endtask

    task automatic put_compute(int b, int h, int w, int oc);
        if (b < sb.n_batch() && h < sb.n_rows() && w < sb.n_cols() && oc < sb.n_ochans())
            fill_gaps(b, h, w, oc);
        put_load(OP_CONV, b, h, w, $urandom_range(0, 15), oc, $urandom_range(0, 7),
                 $urandom_range(0, 7), 16'($urandom));
        computes_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int val, int width);
        logic [15:0] d;
        d = 16'(val) | (width < 16 ? 16'($urandom) << width : 16'd0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    task automatic set_shape(int nb, int nr, int nc, int nch, int noc, int kr, int kc,
                             logic [15:0] fill);
        wait_idle();
        write_reg(REG_BATCH, nb, 2);
        write_reg(REG_ROWS, nr, 6);
        write_reg(REG_COLS, nc, 6);
        write_reg(REG_CHANS, nch, 5);
        write_reg(REG_OCHANS, noc, 5);
        write_reg(REG_KROWS, kr, 3);
        write_reg(REG_KCOLS, kc, 3);
        write_reg(REG_FILL, int'(fill), 16);
        cfg_we <= 1'b0;
    endtask

    // mostly loads and computes inside the active shape, some noise anywhere
    task automatic random_traffic(int count, int conv_pct);
        int sel;
        bit noise;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            noise = ($urandom_range(0, 99) < 15);
            if (sel < conv_pct)
            begin
                if (noise)
                    put_compute($urandom_range(0, 1), $urandom_range(0, 31),
                                $urandom_range(0, 31), $urandom_range(0, 15));
                else
                    put_compute($urandom_range(0, sb.n_batch() - 1),
                                $urandom_range(0, sb.n_rows() - 1),
                                $urandom_range(0, sb.n_cols() - 1),
                                $urandom_range(0, sb.n_ochans() - 1));
            end
            else if (noise)
                put_load(op_t'($urandom_range(0, 2)), $urandom_range(0, 1),
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                         16'($urandom));
            else if (sel < conv_pct + 25)
                put_load(OP_BASE, $urandom_range(0, sb.n_batch() - 1),
                         $urandom_range(0, sb.n_rows() - 1), $urandom_range(0, sb.n_cols() - 1),
                         0, 0, 0, 0, rand_base());
            else if (sel < conv_pct + 50)
                put_load(OP_FILTER, 0, 0, 0, $urandom_range(0, sb.n_chans() - 1),
                         $urandom_range(0, sb.n_ochans() - 1), $urandom_range(0, sb.n_krows() - 1),
                         $urandom_range(0, sb.n_kcols() - 1), rand_sample());
            else
                put_load(OP_IMAGE, $urandom_range(0, sb.n_batch() - 1),
                         $urandom_range(0, sb.n_rows() - 1), $urandom_range(0, sb.n_cols() - 1),
                         $urandom_range(0, sb.n_chans() - 1), 0, 0, 0, rand_sample());
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        computes_sent = 0;
        hold_left = 0;
        send_idle = 20;
        recv_idle = 71;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, extreme samples, ignored and out-of-range beats
        set_shape(2, 4, 4, 4, 2, 3, 3, 16'h7fff);
        put_load(OP_BASE, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
        put_load(OP_BASE, 0, 0, 1, 0, 0, 0, 0, 16'h0080);
        put_load(OP_BASE, 0, 1, 0, 0, 0, 0, 0, 16'hff00);
        put_load(OP_BASE, 0, 1, 1, 0, 0, 0, 0, 16'h0300);
        put_load(OP_IMAGE, 0, 0, 1, 0, 0, 0, 0, 16'h7fff);
        put_load(OP_IMAGE, 0, 0, 1, 1, 0, 0, 0, 16'h8000);
        put_load(OP_FILTER, 0, 0, 0, 0, 1, 7, 3, 16'h1234);
        put_load(OP_FILTER, 0, 0, 0, 0, 1, 2, 7, 16'h4321);
        put_load(OP_FILTER, 0, 0, 0, 3, 1, 2, 2, 16'h8000);
        put_compute(0, 0, 0, 0);
        put_compute(0, 1, 1, 1);
        put_compute(1, 3, 3, 1);
        put_compute(0, 3, 0, 0);
        put_compute(0, 4, 0, 0);
        put_compute(0, 0, 4, 0);
        put_compute(0, 0, 0, 2);
        put_compute(1, 31, 31, 15);
        random_traffic(35, 25);

        set_shape(1, 3, 5, 5, 2, 3, 3, 16'h8000);
        put_compute(1, 0, 0, 0);
        random_traffic(30, 25);
        set_shape(2, 8, 8, 4, 4, 1, 1, 16'($urandom));
        random_traffic(30, 30);

        send_idle = 71;
        recv_idle = 20;
        set_shape(0, 0, 0, 0, 0, 0, 0, 16'($urandom));
        random_traffic(30, 30);
        set_shape(3, 63, 63, 31, 31, 1, 0, 16'($urandom));
        random_traffic(12, 20);

        send_idle = 0;
        recv_idle = 0;
        set_shape(1, 3, 3, 2, 1, 7, 7, 16'h0001);
        hold_left = 4000;
        random_traffic(60, 30);

        wait_idle();
        $display("ran %0d load beats and %0d computes over six register shapes,",
                 sb.loads_seen, computes_sent);
        $display("%0d sums checked, %0d mismatches", sb.sums_seen, sb.errors);
        if (sb.errors == 0 && sb.sums_due.size() == 0)
            $display("channel_shifted_conv2d_forward_tb: PASS");
        else
            $display("channel_shifted_conv2d_forward_tb: FAIL");
        $finish;
    end

endmodule
